/* design/bfdf_pkg.sv */
// ----------------------------------------------------------------------------
// bfdf_pkg
// Shared constants, segment codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bfdf_pkg;

  localparam int unsigned MaxLevel = 20;
  localparam int unsigned FracBits = 16;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned AccW     = CoordW + FracBits;
  localparam int unsigned HW       = 49;
  localparam int unsigned DigW     = 17;
  localparam int unsigned NumDig   = 3;
  localparam int unsigned ProdW    = 80;
  localparam int unsigned OpW      = 35;
  localparam int unsigned DivBits  = 49;
  localparam int unsigned DvW      = 18;
  localparam int unsigned StepW    = 6;
  localparam int unsigned NumJobs  = 6;

  localparam logic [1:0] SEG_LINE  = 2'd0;
  localparam logic [1:0] SEG_QUAD  = 2'd1;
  localparam logic [1:0] SEG_CUBIC = 2'd2;
  localparam logic [1:0] SEG_RSVD  = 2'd3;

  typedef struct packed {
    logic       cfg_we;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic [1:0] hsel;
    logic       accept;
    logic       mul_load;
    logic       mul_step;
    logic       mul_store;
    logic [2:0] job;
    logic [1:0] digit;
    logic       seg_load;
    logic       run;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_step;
  } sts_t;

endpackage

/* design/bfdf_ctrl.sv */
// ----------------------------------------------------------------------------
// bfdf_ctrl
// Sequencer: step reciprocal division, coefficient multiplies, point run.
// ----------------------------------------------------------------------------
module bfdf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  input  logic            cfg_valid_i,
  input  bfdf_pkg::sts_t  sts_i,
  output logic            idle_o,
  output bfdf_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_DINIT, ST_DIV, ST_DSTORE, ST_IDLE, ST_MLOAD, ST_MSTEP, ST_MSTORE, ST_LOAD, ST_RUN
  } state_e;

  state_e     state_q;
  logic [5:0] cnt_q;
  logic [1:0] k_q;
  logic [2:0] job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_DINIT;
      cnt_q   <= '0;
      k_q     <= '0;
      job_q   <= '0;
    end else begin
      unique case (state_q)
        ST_DINIT: begin
          k_q     <= '0;
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(bfdf_pkg::DivBits - 1)) state_q <= ST_DSTORE;
        end
        ST_DSTORE: begin
          cnt_q <= '0;
          if (k_q == 2'd2) begin
            state_q <= ST_IDLE;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= ST_DIV;
          end
        end
        ST_IDLE: begin
          job_q <= '0;
          if (cfg_valid_i) state_q <= ST_DINIT;
          else if (s_valid_i) state_q <= ST_MLOAD;
        end
        ST_MLOAD: begin
          cnt_q   <= '0;
          state_q <= ST_MSTEP;
        end
        ST_MSTEP: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(bfdf_pkg::NumDig - 1)) state_q <= ST_MSTORE;
        end
        ST_MSTORE: begin
          if (job_q == 3'(bfdf_pkg::NumJobs - 1)) begin
            state_q <= ST_LOAD;
          end else begin
            job_q   <= job_q + 3'd1;
            state_q <= ST_MLOAD;
          end
        end
        ST_LOAD: state_q <= ST_RUN;
        ST_RUN: begin
          if (sts_i.out_free && sts_i.last_step) state_q <= ST_IDLE;
        end
        default: state_q <= ST_DINIT;
      endcase
    end
  end

  assign idle_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.hsel      = k_q;
    cmd_o.job       = job_q;
    cmd_o.digit     = cnt_q[1:0];
    cmd_o.cfg_we    = (state_q == ST_IDLE) && cfg_valid_i;
    cmd_o.accept    = (state_q == ST_IDLE) && !cfg_valid_i && s_valid_i;
    cmd_o.div_init  = (state_q == ST_DINIT);
    cmd_o.div_step  = (state_q == ST_DIV);
    cmd_o.div_store = (state_q == ST_DSTORE);
    cmd_o.mul_load  = (state_q == ST_MLOAD);
    cmd_o.mul_step  = (state_q == ST_MSTEP);
    cmd_o.mul_store = (state_q == ST_MSTORE);
    cmd_o.seg_load  = (state_q == ST_LOAD);
    cmd_o.run       = (state_q == ST_RUN);
  end

endmodule

/* design/bfdf_dpath.sv */
// ----------------------------------------------------------------------------
// bfdf_dpath
// Reciprocal divider, digit-serial multiplier, difference accumulators, output.
// ----------------------------------------------------------------------------
module bfdf_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bfdf_pkg::cmd_t       cmd_i,
  output bfdf_pkg::sts_t       sts_o,
  input  logic [4:0]           cfg_data_i,
  input  logic [1:0]           seg_type_i,
  input  logic [255:0]         pts_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic [31:0]          point_x_o,
  output logic [31:0]          point_y_o,
  output logic                 last_point_o
);

  localparam int unsigned AW = bfdf_pkg::AccW;

  logic [4:0]                   lvl_q;
  logic [bfdf_pkg::StepW-1:0]   steps_c;
  logic [4:0]                   lvl_c;

  logic [bfdf_pkg::DvW-1:0]     dv_q, dv_nx;
  logic [bfdf_pkg::DvW-1:0]     rem_q;
  logic [bfdf_pkg::DvW:0]       rsh;
  logic [bfdf_pkg::DivBits-1:0] num_q, quo_q;
  logic [bfdf_pkg::HW-1:0]      h_q [3];

  logic [1:0]                   kind_q;
  logic [31:0]                  pt_q [8];

  logic [bfdf_pkg::OpW-1:0]     a_q;
  logic                         neg_q;
  logic [bfdf_pkg::ProdW-1:0]   prod_q;
  logic [AW-1:0]                m_q [bfdf_pkg::NumJobs];

  logic [AW-1:0] pos_q [2], f1_q [2], sd_q [2], hs_q [2], t6_q [2], t2_q [2], t3_q [2];
  logic [bfdf_pkg::StepW-1:0]   sl_q;
  logic                         ov_q, olast_q;
  logic [31:0]                  ox_q, oy_q;

  logic                         out_free, step_en;

  // operand select
  logic [bfdf_pkg::OpW-1:0] q0, q1, q2, q3, xb, xc, xd, xsel, xabs;
  logic [bfdf_pkg::HW+1:0]  hsel;
  logic [bfdf_pkg::DigW-1:0] dig;
  logic [bfdf_pkg::DigW+bfdf_pkg::OpW-1:0] pp;
  logic [bfdf_pkg::ProdW-1:0] ppsh, prnd;
  logic [AW-1:0]            mag;

  function automatic logic [31:0] rnd_out(input logic [AW-1:0] acc);
    logic [AW:0]   v;
    logic [AW-16:0] q;
    v = {acc[AW-1], acc} + (AW+1)'(1 << (bfdf_pkg::FracBits - 1));
    q = v[AW:bfdf_pkg::FracBits];
    if (!q[AW-16] && q[AW-17]) rnd_out = 32'h7FFF_FFFF;
    else if (q[AW-16] && !q[AW-17]) rnd_out = 32'h8000_0000;
    else rnd_out = q[31:0];
  endfunction

  assign lvl_c   = (lvl_q > 5'(bfdf_pkg::MaxLevel)) ? 5'(bfdf_pkg::MaxLevel) : lvl_q;
  assign steps_c = bfdf_pkg::StepW'(lvl_c) * 6'd3 + 6'd2;
  assign rsh     = {rem_q, num_q[bfdf_pkg::DivBits-1]};
  assign dv_nx   = bfdf_pkg::DvW'(dv_q * bfdf_pkg::DvW'(steps_c));

  assign q0 = bfdf_pkg::OpW'($signed(cmd_i.job[0] ? pt_q[1] : pt_q[0]));
  assign q1 = bfdf_pkg::OpW'($signed(cmd_i.job[0] ? pt_q[3] : pt_q[2]));
  assign q2 = bfdf_pkg::OpW'($signed(cmd_i.job[0] ? pt_q[5] : pt_q[4]));
  assign q3 = bfdf_pkg::OpW'($signed(cmd_i.job[0] ? pt_q[7] : pt_q[6]));
  assign xb = q1 - q0;
  assign xc = q0 - (q1 << 1) + q2;
  assign xd = ((q1 - q2) << 1) + (q1 - q2) + q3 - q0;

  always_comb begin
    unique case (cmd_i.job[2:1])
      2'd0:    xsel = xb;
      2'd1:    xsel = xc;
      default: xsel = xd;
    endcase
    xabs = xsel[bfdf_pkg::OpW-1] ? (~xsel + 1'b1) : xsel;
    unique case (cmd_i.job[2:1])
      2'd0:    hsel = {2'b0, h_q[0]};
      2'd1:    hsel = {2'b0, h_q[1]};
      default: hsel = {2'b0, h_q[2]};
    endcase
    unique case (cmd_i.digit)
      2'd0:    dig = hsel[bfdf_pkg::DigW-1:0];
      2'd1:    dig = hsel[2*bfdf_pkg::DigW-1:bfdf_pkg::DigW];
      default: dig = hsel[3*bfdf_pkg::DigW-1:2*bfdf_pkg::DigW];
    endcase
    pp = a_q * dig;
    unique case (cmd_i.digit)
      2'd0:    ppsh = bfdf_pkg::ProdW'(pp);
      2'd1:    ppsh = bfdf_pkg::ProdW'(pp) << bfdf_pkg::DigW;
      default: ppsh = bfdf_pkg::ProdW'(pp) << (2 * bfdf_pkg::DigW);
    endcase
    prnd = prod_q + (bfdf_pkg::ProdW'(1) << 31);
    mag  = prnd[AW+31:32];
  end

  assign out_free = !ov_q || out_ready_i;
  assign step_en  = cmd_i.run && out_free;
  assign sts_o.out_free  = out_free;
  assign sts_o.last_step = (sl_q == 6'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '0;
      sl_q  <= '0;
      ov_q  <= 1'b0;
    end else begin
      if (cmd_i.cfg_we) lvl_q <= cfg_data_i;
      if (step_en) begin
        ov_q <= 1'b1;
        sl_q <= sl_q - 6'd1;
      end else begin
        if (out_ready_i) ov_q <= 1'b0;
        if (cmd_i.seg_load) begin
          sl_q <= (kind_q == bfdf_pkg::SEG_QUAD || kind_q == bfdf_pkg::SEG_CUBIC) ?
                  steps_c : 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dv_q  <= bfdf_pkg::DvW'(steps_c);
      num_q <= {1'b1, 48'b0} + bfdf_pkg::DivBits'(steps_c >> 1);
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      if (rsh >= {1'b0, dv_q}) begin
        rem_q <= bfdf_pkg::DvW'(rsh - {1'b0, dv_q});
        quo_q <= {quo_q[bfdf_pkg::DivBits-2:0], 1'b1};
      end else begin
        rem_q <= rsh[bfdf_pkg::DvW-1:0];
        quo_q <= {quo_q[bfdf_pkg::DivBits-2:0], 1'b0};
      end
    end
    if (cmd_i.div_store) begin
      h_q[cmd_i.hsel] <= quo_q;
      dv_q  <= dv_nx;
      num_q <= {1'b1, 48'b0} + bfdf_pkg::DivBits'(dv_nx >> 1);
      rem_q <= '0;
    end
    if (cmd_i.accept) begin
      kind_q <= seg_type_i;
      for (int i = 0; i < 8; i++) pt_q[i] <= pts_i[32*i +: 32];
    end
    if (cmd_i.mul_load) begin
      a_q    <= xabs;
      neg_q  <= xsel[bfdf_pkg::OpW-1];
      prod_q <= '0;
    end
    if (cmd_i.mul_step) prod_q <= prod_q + ppsh;
    if (cmd_i.mul_store) m_q[cmd_i.job] <= neg_q ? (~mag + 1'b1) : mag;
    if (cmd_i.seg_load) begin
      for (int a = 0; a < 2; a++) begin
        pos_q[a] <= {pt_q[a], 16'b0};
        unique case (kind_q)
          bfdf_pkg::SEG_QUAD: begin
            f1_q[a] <= m_q[a] << 1;
            hs_q[a] <= m_q[2+a];
            sd_q[a] <= m_q[2+a] << 1;
            t6_q[a] <= '0;
            t2_q[a] <= '0;
            t3_q[a] <= '0;
          end
          bfdf_pkg::SEG_CUBIC: begin
            f1_q[a] <= (m_q[a] << 1) + m_q[a];
            hs_q[a] <= (m_q[2+a] << 1) + m_q[2+a];
            sd_q[a] <= (m_q[2+a] << 2) + (m_q[2+a] << 1);
            t6_q[a] <= m_q[4+a];
            t2_q[a] <= (m_q[4+a] << 1) + m_q[4+a];
            t3_q[a] <= (m_q[4+a] << 2) + (m_q[4+a] << 1);
          end
          default: begin
            f1_q[a] <= '0;
            hs_q[a] <= '0;
            sd_q[a] <= '0;
            t6_q[a] <= '0;
            t2_q[a] <= '0;
            t3_q[a] <= '0;
          end
        endcase
      end
    end
    if (step_en) begin
      ox_q    <= rnd_out(pos_q[0]);
      oy_q    <= rnd_out(pos_q[1]);
      olast_q <= (sl_q == 6'd1);
      for (int a = 0; a < 2; a++) begin
        pos_q[a] <= pos_q[a] + f1_q[a] + hs_q[a] + t6_q[a];
        f1_q[a]  <= f1_q[a] + sd_q[a] + t2_q[a];
        sd_q[a]  <= sd_q[a] + t3_q[a];
        hs_q[a]  <= hs_q[a] + t2_q[a];
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign point_x_o    = ox_q;
  assign point_y_o    = oy_q;
  assign last_point_o = olast_q;

endmodule

/* design/bezier_forward_difference_flatten.sv */
// ----------------------------------------------------------------------------
// bezier_forward_difference_flatten
// Flattens line, quadratic and cubic Bezier segments into Q16.16 points.
// ----------------------------------------------------------------------------
// channel   | direction | payload
// s_axis    | in        | tuser seg_type; tdata p0_x..p3_y
// m_axis    | out       | tdata point_x, point_y; tlast last_point
// cfg       | in        | data detail_level
//
// After reset and after each cfg write, the step reciprocals are rebuilt by a
// one-bit-per-cycle divider, and no requests are taken meanwhile.
// A segment first runs the digit-serial coefficient multiplies, then emits one
// point per cycle (1 for a line, 3*(level+1)-1 for a curve).
// m_axis stalls hold the point run; the next segment is accepted once the last
// point sits in the output register.
// ----------------------------------------------------------------------------
module bezier_forward_difference_flatten (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [255:0] s_axis_tdata,  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
  input  logic [1:0]   s_axis_tuser,  // seg_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // point_x, point_y
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [4:0]   cfg_data_i
);

  bfdf_pkg::cmd_t cmd;
  bfdf_pkg::sts_t sts;
  logic           idle;
  logic [31:0]    px, py;

  bfdf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .cfg_valid_i (cfg_valid_i),
    .sts_i       (sts),
    .idle_o      (idle),
    .cmd_o       (cmd)
  );

  bfdf_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_data_i   (cfg_data_i),
    .seg_type_i   (s_axis_tuser),
    .pts_i        (s_axis_tdata),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .point_x_o    (px),
    .point_y_o    (py),
    .last_point_o (m_axis_tlast)
  );

  assign cfg_ready_o   = idle;
  assign s_axis_tready = idle && !cfg_valid_i;
  assign m_axis_tdata  = {py, px};

endmodule
